@@ design/erg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_pkg
// Shared constants, types and state codes of the Euclidean rhythm generator.
// ----------------------------------------------------------------------------
package erg_pkg;

  localparam int MAX_STEPS   = 64;
  localparam int MAX_LEVELS  = 16;
  localparam int STACK_DEPTH = MAX_LEVELS + 2;
  localparam int STEP_LIMIT  = (MAX_STEPS < 64) ? MAX_STEPS : 64;
  localparam int CNT_W       = 7;
  localparam int IDX_W       = 6;
  localparam int LVL_W       = $clog2(MAX_LEVELS);
  localparam int REM_W       = $clog2(MAX_LEVELS + 1);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [1:0] {
    JOB_BAD,
    JOB_ZERO,
    JOB_RUN
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [CNT_W-1:0]   step_count;
    logic [CNT_W-1:0]   pulse_count;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_PUSH,
    B_EXP,
    B_ZERO,
    B_BAD
  } back_state_t;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [CNT_W-1:0] left;
    logic             tail;
  } frame_t;

endpackage

@@ design/erg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_if
// Request and rhythm channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface erg_req_if;
  logic       valid;
  logic       ready;
  logic [6:0] step_count;
  logic [6:0] pulse_count;
  modport source (output valid, step_count, pulse_count, input ready);
  modport sink (input valid, step_count, pulse_count, output ready);
endinterface

interface erg_beat_if;
  logic       valid;
  logic       ready;
  logic       beat;
  logic [5:0] step_index;
  logic       last_step;
  logic       bad_request;
  modport source (output valid, beat, step_index, last_step, bad_request, input ready);
  modport sink (input valid, beat, step_index, last_step, bad_request, output ready);
endinterface

@@ design/erg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module erg_front (
  input  logic          clk,
  input  logic          rst,
  erg_req_if.sink       req,
  output logic          job_valid,
  output erg_pkg::job_t job,
  input  logic          job_pop
);
  import erg_pkg::*;

  job_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  job_t              incoming;
  logic              push;
  logic              pop;

  always_comb begin
    incoming.step_count  = req.step_count;
    incoming.pulse_count = req.pulse_count;
    if (req.step_count == '0 || req.step_count > CNT_W'(STEP_LIMIT) ||
        req.pulse_count > req.step_count) begin
      incoming.kind = JOB_BAD;
    end else if (req.pulse_count == '0) begin
      incoming.kind = JOB_ZERO;
    end else begin
      incoming.kind = JOB_RUN;
    end
  end

  assign req.ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign pop       = job_pop && job_valid;
  assign job_valid = (fill != '0);
  assign job       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

@@ design/erg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_back
// Runs the Euclidean division, expands the tables and emits one bit per item.
// ----------------------------------------------------------------------------
module erg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  erg_pkg::job_t job,
  output logic          job_pop,
  erg_beat_if.source    rhythm
);
  import erg_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  count_table [MAX_LEVELS];
  logic [CNT_W-1:0]  remainder_table [MAX_LEVELS + 1];
  frame_t            stack [STACK_DEPTH];
  logic [SP_W-1:0]   sp;
  logic [CNT_W-1:0]  dvd;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W-1:0]  quo;
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  top;
  logic [CNT_W-1:0]  steps;
  logic [IDX_W-1:0]  idx;
  logic              ov;
  logic              ob_beat;
  logic [IDX_W-1:0]  ob_index;
  logic              ob_last;
  logic              ob_bad;

  frame_t            f;
  logic [LVL_W-1:0]  lvl_inc;
  logic [LVL_W-1:0]  plvl;
  logic              slot_free;
  logic              emit;
  logic              emit_bit;
  logic              do_push;
  logic              do_pop;
  logic              do_dec;
  logic              do_tail;
  logic              stall;
  logic              is_last;
  logic              div_more;

  assign f         = stack[SP_W'(sp - 1'b1)];
  assign lvl_inc   = level + 1'b1;
  assign slot_free = !ov || rhythm.ready;
  assign is_last   = ({1'b0, idx} == steps - 1'b1);
  assign div_more  = (dvd > CNT_W'(1)) && (32'(lvl_inc) < MAX_LEVELS - 1);

  always_comb begin
    emit     = 1'b0;
    emit_bit = 1'b0;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_dec   = 1'b0;
    do_tail  = 1'b0;
    plvl     = '0;
    case (state)
      B_EXP: begin
        if (sp != '0) begin
          if (f.left != '0) begin
            do_dec = 1'b1;
            if (f.lvl == '0) begin
              emit = 1'b1;
            end else begin
              do_push = 1'b1;
              plvl    = f.lvl - 1'b1;
            end
          end else if (f.tail) begin
            do_tail = 1'b1;
            if (remainder_table[REM_W'(f.lvl)] != '0) begin
              if (f.lvl == '0) begin
                emit     = 1'b1;
                emit_bit = 1'b1;
              end else if (f.lvl == LVL_W'(1)) begin
                emit = 1'b1;
              end else begin
                do_push = 1'b1;
                plvl    = f.lvl - LVL_W'(2);
              end
            end
          end else begin
            do_pop = 1'b1;
          end
        end
      end
      B_ZERO, B_BAD: begin
        emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign stall   = emit && !slot_free;
  assign job_pop = (state == B_IDLE) && job_valid;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          case (job.kind)
            JOB_BAD:  state_next = B_BAD;
            JOB_ZERO: state_next = B_ZERO;
            default:  state_next = B_DIV;
          endcase
        end
      end
      B_DIV: begin
        if (dvd < dvs && !div_more) begin
          state_next = B_PUSH;
        end
      end
      B_PUSH: state_next = B_EXP;
      B_EXP: begin
        if (sp == '0) begin
          state_next = B_IDLE;
        end
      end
      B_ZERO: begin
        if (!stall && is_last) begin
          state_next = B_IDLE;
        end
      end
      B_BAD: begin
        if (!stall) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      sp    <= '0;
      ov    <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (emit && !stall) begin
        ov  <= 1'b1;
        idx <= idx + 1'b1;
      end else if (rhythm.ready) begin
        ov <= 1'b0;
      end
      if (state == B_IDLE) begin
        idx <= '0;
      end
      if (state == B_PUSH) begin
        sp <= SP_W'(1);
      end else if (state == B_EXP && !stall) begin
        if (do_pop) begin
          sp <= sp - 1'b1;
        end else if (do_push && 32'(sp) < STACK_DEPTH) begin
          sp <= sp + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !stall) begin
      ob_beat  <= emit_bit;
      ob_index <= (state == B_BAD) ? '0 : idx;
      ob_last  <= (state == B_BAD) ? 1'b1 : is_last;
      ob_bad   <= (state == B_BAD);
    end
    case (state)
      B_IDLE: begin
        steps              <= job.step_count;
        dvd                <= job.step_count - job.pulse_count;
        dvs                <= job.pulse_count;
        quo                <= '0;
        level              <= '0;
        remainder_table[0] <= job.pulse_count;
      end
      B_DIV: begin
        if (dvd >= dvs) begin
          dvd <= dvd - dvs;
          quo <= quo + 1'b1;
        end else begin
          count_table[level]                <= quo;
          remainder_table[REM_W'(lvl_inc)] <= dvd;
          if (div_more) begin
            level <= lvl_inc;
            dvs   <= dvd;
            dvd   <= dvs;
            quo   <= '0;
          end else begin
            count_table[lvl_inc] <= dvs;
            top                  <= lvl_inc;
          end
        end
      end
      B_PUSH: begin
        stack[0] <= '{lvl: top, left: count_table[top], tail: 1'b1};
      end
      B_EXP: begin
        if (sp != '0 && !stall) begin
          if (do_dec) begin
            stack[SP_W'(sp - 1'b1)].left <= f.left - 1'b1;
          end
          if (do_tail) begin
            stack[SP_W'(sp - 1'b1)].tail <= 1'b0;
          end
          if (do_push && 32'(sp) < STACK_DEPTH) begin
            stack[sp] <= '{lvl: plvl, left: count_table[plvl], tail: 1'b1};
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rhythm.valid       = ov;
  assign rhythm.beat        = ob_beat;
  assign rhythm.step_index  = ob_index;
  assign rhythm.last_step   = ob_last;
  assign rhythm.bad_request = ob_bad;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sp) <= STACK_DEPTH) else $error("stack pointer beyond depth");
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    ov && ob_bad |-> ob_last && ob_index == '0) else $error("bad result not single");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == B_IDLE |-> sp == '0) else $error("stack not empty when idle");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> state != B_IDLE) else $error("job taken but back end idle");
`endif

endmodule

@@ design/euclidean_rhythm_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_rhythm_generator
// Euclidean rhythm generator: one request in, one item per step out (a single item for a rejected request).
// ----------------------------------------------------------------------------
// Channel   Dir   Payload
// req       in    step_count[6:0], pulse_count[6:0]
// rhythm    out   beat, step_index[5:0], last_step, bad_request
//
// A request passes the idle state, then the division by repeated subtraction
// (fewer than step_count subtractions in all) level by level, a step that
// seeds the stack, and the stack expansion that emits the steps. A rejected
// request gives one item, a zero pulse count one item per step. Two requests
// queue ahead of the engine. Reset is synchronous and clears the queue, the
// engine and the output valid flag. A stalled rhythm channel holds the engine.
module euclidean_rhythm_generator (
  input  logic       clk,
  input  logic       rst,
  erg_req_if.sink    req,
  erg_beat_if.source rhythm
);
  import erg_pkg::*;

  logic job_valid;
  job_t job;
  logic job_pop;

  erg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  erg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .rhythm    (rhythm)
  );

endmodule
